// ===== hdl/susq_pkg.sv =====
// shared types, codes and constants of the save-under sprite sequencer
// no dependencies; imported by susq_ctrl, susq_dpath and the top level
package susq_pkg;

    // default sizes handed to the top level parameters
    localparam int SLOTS_DEF       = 8;
    localparam int UNDER_BYTES_DEF = 96;

    // visible screen limits for a drawn sprite
    localparam logic [15:0] X_MAX = 16'd279;
    localparam logic [7:0]  Y_MAX = 8'd191;

    // command codes
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_DEFINE = 3'd1;
    localparam logic [2:0] CMD_MOVE   = 3'd2;
    localparam logic [2:0] CMD_HIDE   = 3'd3;
    localparam logic [2:0] CMD_UPDATE = 3'd4;

    // operation codes on the result side
    typedef logic [2:0] op_t;
    localparam op_t OP_ACK     = 3'd0;
    localparam op_t OP_WAIT    = 3'd1;
    localparam op_t OP_SELECT  = 3'd2;
    localparam op_t OP_SHOW    = 3'd3;
    localparam op_t OP_RESTORE = 3'd4;
    localparam op_t OP_DRAW    = 3'd5;

    // status codes of the acknowledge
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_OVERSIZE = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;          // latch the accepted item
        logic apply;         // apply define, move or hide
        logic clear_all;     // init clearing of shapes, active and drawn flags
        logic emit;          // register one result
        op_t  op;
        logic page_from_reg; // result page is the draw page register
        logic page_val;      // otherwise this page, also the value for set_page
        logic last;
        logic set_page;
        logic toggle_page;
        logic idx_top;
        logic idx_zero;
        logic idx_dec;
        logic idx_inc;
    } susq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic dbl;        // double buffered mode
        logic any_rest;   // some slot drawn on the draw page
        logic any_draw;   // some slot to draw
        logic rest_cur;   // slot under the scan index is to restore
        logic rest_below; // a slot to restore below the scan index
        logic draw_cur;   // slot under the scan index is to draw
        logic draw_above; // a slot to draw above the scan index
    } susq_sts_t;

endpackage

// ===== hdl/susq_dpath.sv =====
// datapath of the sprite sequencer: slot tables, drawn tables, scan index,
// size check and result registers; depends on susq_pkg
module susq_dpath #(
    parameter int SLOTS       = susq_pkg::SLOTS_DEF,
    parameter int UNDER_BYTES = susq_pkg::UNDER_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  susq_pkg::susq_cmd_t cmd,
    output susq_pkg::susq_sts_t sts,
    input  logic                cfg_we,
    input  logic                cfg_data,
    input  logic [2:0]          command,
    input  logic [7:0]          slot,
    input  logic [7:0]          shape_handle,
    input  logic [7:0]          shape_stride,
    input  logic [7:0]          shape_rows,
    input  logic [15:0]         x_pos,
    input  logic [7:0]          y_pos,
    output logic                result_valid,
    output logic [2:0]          op,
    output logic [1:0]          status,
    output logic                page_index,
    output logic [2:0]          sprite_slot,
    output logic [8:0]          draw_x,
    output logic [7:0]          draw_y,
    output logic [7:0]          shape_out,
    output logic [10:0]         under_offset,
    output logic                last
);
    import susq_pkg::*;

    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PAGE_OFF = SLOTS * UNDER_BYTES;

    // configuration and page state
    logic dbl_reg;
    logic page_reg;

    // latched item
    logic [2:0]  cmd_code_reg;
    logic [7:0]  slot_reg;
    logic [7:0]  shape_in_reg;
    logic [7:0]  stride_reg;
    logic [7:0]  rows_reg;
    logic [15:0] x_in_reg;
    logic [7:0]  y_in_reg;

    // per slot state
    logic [7:0]  shape_reg    [SLOTS];
    logic [15:0] target_x_reg [SLOTS];
    logic [7:0]  target_y_reg [SLOTS];
    logic        active_reg   [SLOTS];

    // per page and slot drawn state
    logic [8:0] drawn_x_reg [2][SLOTS];
    logic [7:0] drawn_y_reg [2][SLOTS];
    logic       flag_reg    [2][SLOTS];

    logic [SLOT_W-1:0] idx_reg;

    // result registers
    logic        valid_reg;
    logic [2:0]  op_reg;
    logic [1:0]  status_reg;
    logic        page_out_reg;
    logic [2:0]  sslot_reg;
    logic [8:0]  x_out_reg;
    logic [7:0]  y_out_reg;
    logic [7:0]  shape_out_reg;
    logic [10:0] off_reg;
    logic        last_reg;

    logic [SLOTS-1:0]  rest_mask;
    logic [SLOTS-1:0]  draw_mask;
    logic [SLOTS-1:0]  rest_below_mask;
    logic [SLOTS-1:0]  draw_above_mask;
    logic              in_range;
    logic [SLOT_W-1:0] sidx;
    logic [15:0]       size_prod;
    logic              oversize;
    logic [1:0]        ack_status;
    logic [31:0]       off_full;
    logic [7:0]        idx_wide;
    logic              emit_page;
    logic              is_restore;
    logic              is_draw;

    // scan masks over the slots
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            rest_mask[i] = flag_reg[page_reg][i];
            draw_mask[i] = active_reg[i] && (shape_reg[i] != 8'd0)
                && (target_x_reg[i] <= X_MAX) && (target_y_reg[i] <= Y_MAX);
            rest_below_mask[i] = rest_mask[i] && (i < int'(idx_reg));
            draw_above_mask[i] = draw_mask[i] && (i > int'(idx_reg));
        end
    end

    assign sts.dbl        = dbl_reg;
    assign sts.any_rest   = |rest_mask;
    assign sts.any_draw   = |draw_mask;
    assign sts.rest_cur   = rest_mask[idx_reg];
    assign sts.rest_below = |rest_below_mask;
    assign sts.draw_cur   = draw_mask[idx_reg];
    assign sts.draw_above = |draw_above_mask;

    // slot range and shape size check of the latched item
    assign in_range  = slot_reg < 8'(SLOTS);
    assign sidx      = slot_reg[SLOT_W-1:0];
    assign size_prod = 16'(stride_reg) * 16'(rows_reg);
    assign oversize  = (shape_in_reg != 8'd0) && (size_prod > 16'(UNDER_BYTES));

    always_comb
    begin
        priority if ((cmd_code_reg == CMD_DEFINE || cmd_code_reg == CMD_MOVE
                      || cmd_code_reg == CMD_HIDE) && !in_range)
            ack_status = ST_RANGE;
        else if (cmd_code_reg == CMD_DEFINE && oversize)
            ack_status = ST_OVERSIZE;
        else
            ack_status = ST_OK;
    end

    // save buffer offset of the scanned slot
    assign off_full   = (page_reg ? 32'(PAGE_OFF) : 32'd0)
                      + 32'(idx_reg) * 32'(UNDER_BYTES);
    assign idx_wide   = 8'(idx_reg);
    assign emit_page  = cmd.page_from_reg ? page_reg : cmd.page_val;
    assign is_restore = cmd.emit && (cmd.op == OP_RESTORE);
    assign is_draw    = cmd.emit && (cmd.op == OP_DRAW);

    // configuration, page and scan index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbl_reg  <= 1'b0;
            page_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                dbl_reg <= cfg_data;
            if (cmd.set_page)
                page_reg <= cmd.page_val;
            else if (cmd.toggle_page)
                page_reg <= ~page_reg;
            priority if (cmd.idx_top)
                idx_reg <= SLOT_W'(SLOTS - 1);
            else if (cmd.idx_zero)
                idx_reg <= '0;
            else if (cmd.idx_dec)
                idx_reg <= idx_reg - 1'b1;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            else
                idx_reg <= idx_reg;
        end
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_code_reg <= command;
            slot_reg     <= slot;
            shape_in_reg <= shape_handle;
            stride_reg   <= shape_stride;
            rows_reg     <= shape_rows;
            x_in_reg     <= x_pos;
            y_in_reg     <= y_pos;
        end
    end

    // slot state and drawn flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                shape_reg[i]    <= 8'd0;
                target_x_reg[i] <= 16'd0;
                target_y_reg[i] <= 8'd0;
                active_reg[i]   <= 1'b0;
                flag_reg[0][i]  <= 1'b0;
                flag_reg[1][i]  <= 1'b0;
            end
        end
        else if (cmd.clear_all)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                shape_reg[i]   <= 8'd0;
                active_reg[i]  <= 1'b0;
                flag_reg[0][i] <= 1'b0;
                flag_reg[1][i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.apply && in_range)
            begin
                unique case (cmd_code_reg)
                    CMD_DEFINE:
                    begin
                        shape_reg[sidx]  <= oversize ? 8'd0 : shape_in_reg;
                        active_reg[sidx] <= !oversize && (shape_in_reg != 8'd0);
                    end
                    CMD_MOVE:
                    begin
                        target_x_reg[sidx] <= x_in_reg;
                        target_y_reg[sidx] <= y_in_reg;
                        active_reg[sidx]   <= shape_reg[sidx] != 8'd0;
                    end
                    CMD_HIDE:
                        active_reg[sidx] <= 1'b0;
                    default:
                    begin
                    end
                endcase
            end
            if (is_restore)
                flag_reg[page_reg][idx_reg] <= 1'b0;
            else if (is_draw)
                flag_reg[page_reg][idx_reg] <= 1'b1;
        end
    end

    // drawn positions, only read where the drawn flag is set
    always_ff @(posedge clk)
    begin
        if (is_draw)
        begin
            drawn_x_reg[page_reg][idx_reg] <= target_x_reg[idx_reg][8:0];
            drawn_y_reg[page_reg][idx_reg] <= target_y_reg[idx_reg];
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.emit;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            op_reg        <= cmd.op;
            last_reg      <= cmd.last;
            status_reg    <= (cmd.op == OP_ACK) ? ack_status : ST_OK;
            page_out_reg  <= (cmd.op == OP_ACK || cmd.op == OP_WAIT) ? 1'b0 : emit_page;
            if (is_restore || is_draw)
            begin
                sslot_reg     <= idx_wide[2:0];
                shape_out_reg <= shape_reg[idx_reg];
                off_reg       <= off_full[10:0];
                x_out_reg     <= is_restore ? drawn_x_reg[page_reg][idx_reg]
                                            : target_x_reg[idx_reg][8:0];
                y_out_reg     <= is_restore ? drawn_y_reg[page_reg][idx_reg]
                                            : target_y_reg[idx_reg];
            end
            else
            begin
                sslot_reg     <= 3'd0;
                shape_out_reg <= 8'd0;
                off_reg       <= 11'd0;
                x_out_reg     <= 9'd0;
                y_out_reg     <= 8'd0;
            end
        end
    end

    assign result_valid = valid_reg;
    assign op           = op_reg;
    assign status       = status_reg;
    assign page_index   = page_out_reg;
    assign sprite_slot  = sslot_reg;
    assign draw_x       = x_out_reg;
    assign draw_y       = y_out_reg;
    assign shape_out    = shape_out_reg;
    assign under_offset = off_reg;
    assign last         = last_reg;

endmodule

// ===== hdl/susq_ctrl.sv =====
// controller state machine of the sprite sequencer: walks each command's
// run of results and drives the datapath; depends on susq_pkg
module susq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          command,
    input  susq_pkg::susq_sts_t sts,
    output susq_pkg::susq_cmd_t cmd,
    output logic                busy
);
    import susq_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ACK       = 4'd1;
    localparam logic [3:0] S_INIT_SEL0 = 4'd2;
    localparam logic [3:0] S_INIT_SHOW = 4'd3;
    localparam logic [3:0] S_INIT_SEL1 = 4'd4;
    localparam logic [3:0] S_UPD_WAIT  = 4'd5;
    localparam logic [3:0] S_UPD_SEL   = 4'd6;
    localparam logic [3:0] S_RESTORE   = 4'd7;
    localparam logic [3:0] S_DRAW      = 4'd8;
    localparam logic [3:0] S_DB_WAIT   = 4'd9;
    localparam logic [3:0] S_DB_SHOW   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    priority if (command == CMD_INIT)
                        state_next = S_INIT_SEL0;
                    else if (command == CMD_UPDATE)
                        state_next = sts.dbl ? S_UPD_SEL : S_UPD_WAIT;
                    else
                        state_next = S_ACK;
                end
            end
            S_ACK:
            begin
                cmd.apply  = 1'b1;
                cmd.emit   = 1'b1;
                cmd.op     = OP_ACK;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
            end
            S_INIT_SEL0:
            begin
                cmd.clear_all = 1'b1;
                cmd.emit      = 1'b1;
                cmd.op        = OP_SELECT;
                state_next    = S_INIT_SHOW;
            end
            S_INIT_SHOW:
            begin
                cmd.emit     = 1'b1;
                cmd.op       = OP_SHOW;
                cmd.last     = !sts.dbl;
                cmd.set_page = !sts.dbl;
                state_next   = sts.dbl ? S_INIT_SEL1 : S_IDLE;
            end
            S_INIT_SEL1:
            begin
                cmd.emit     = 1'b1;
                cmd.op       = OP_SELECT;
                cmd.page_val = 1'b1;
                cmd.set_page = 1'b1;
                cmd.last     = 1'b1;
                state_next   = S_IDLE;
            end
            S_UPD_WAIT:
            begin
                cmd.emit   = 1'b1;
                cmd.op     = OP_WAIT;
                state_next = S_UPD_SEL;
            end
            S_UPD_SEL:
            begin
                cmd.emit          = 1'b1;
                cmd.op            = OP_SELECT;
                cmd.page_from_reg = 1'b1;
                cmd.last          = !sts.any_rest && !sts.any_draw && !sts.dbl;
                cmd.idx_top       = sts.any_rest;
                cmd.idx_zero      = !sts.any_rest;
                priority if (sts.any_rest)
                    state_next = S_RESTORE;
                else if (sts.any_draw)
                    state_next = S_DRAW;
                else if (sts.dbl)
                    state_next = S_DB_WAIT;
                else
                    state_next = S_IDLE;
            end
            S_RESTORE:
            begin
                // highest slot first, skip slots not drawn
                cmd.emit          = sts.rest_cur;
                cmd.op            = OP_RESTORE;
                cmd.page_from_reg = 1'b1;
                cmd.last          = !sts.rest_below && !sts.any_draw && !sts.dbl;
                cmd.idx_dec       = 1'b1;
                if (!sts.rest_below)
                begin
                    cmd.idx_zero = 1'b1;
                    priority if (sts.any_draw)
                        state_next = S_DRAW;
                    else if (sts.dbl)
                        state_next = S_DB_WAIT;
                    else
                        state_next = S_IDLE;
                end
            end
            S_DRAW:
            begin
                // lowest slot first, skip slots not to draw
                cmd.emit          = sts.draw_cur;
                cmd.op            = OP_DRAW;
                cmd.page_from_reg = 1'b1;
                cmd.last          = !sts.draw_above && !sts.dbl;
                cmd.idx_inc       = 1'b1;
                if (!sts.draw_above)
                    state_next = sts.dbl ? S_DB_WAIT : S_IDLE;
            end
            S_DB_WAIT:
            begin
                cmd.emit   = 1'b1;
                cmd.op     = OP_WAIT;
                state_next = S_DB_SHOW;
            end
            S_DB_SHOW:
            begin
                cmd.emit          = 1'b1;
                cmd.op            = OP_SHOW;
                cmd.page_from_reg = 1'b1;
                cmd.last          = 1'b1;
                cmd.toggle_page   = 1'b1;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != S_IDLE;

endmodule

// ===== hdl/save_under_sprite_sequencer_core.sv =====
// Results: an item's first result shows in the cycle after the control state that makes it;
// acks come from the ack state; init emits select, show and, in double mode, a second select.
// Update: one slot per cycle in each scan, set by the
// controller's restore and draw walks; busy is low again while the last result is shown.
// Reset: slot tables, drawn flags, draw page and mode clear asynchronously; no clearing pass.
// Results carry a one-cycle strobe and cannot be held off by the receiver.
module save_under_sprite_sequencer_core #(
    parameter int SLOTS       = susq_pkg::SLOTS_DEF,
    parameter int UNDER_BYTES = susq_pkg::UNDER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [7:0]  slot,
    input  logic [7:0]  shape_handle,
    input  logic [7:0]  shape_stride,
    input  logic [7:0]  shape_rows,
    input  logic [15:0] x_pos,
    input  logic [7:0]  y_pos,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        two_page,
    output logic        result_valid,
    output logic [2:0]  op,
    output logic [1:0]  status,
    output logic        page_index,
    output logic [2:0]  sprite_slot,
    output logic [8:0]  draw_x,
    output logic [7:0]  draw_y,
    output logic [7:0]  shape_out,
    output logic [10:0] under_offset,
    output logic        last
);
    import susq_pkg::*;

    susq_cmd_t cmd;
    susq_sts_t sts;
    logic      busy_int;

    // sequencing
    susq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy_int)
    );

    // state and result registers
    susq_dpath #(
        .SLOTS       (SLOTS),
        .UNDER_BYTES (UNDER_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (two_page),
        .command      (command),
        .slot         (slot),
        .shape_handle (shape_handle),
        .shape_stride (shape_stride),
        .shape_rows   (shape_rows),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .result_valid (result_valid),
        .op           (op),
        .status       (status),
        .page_index   (page_index),
        .sprite_slot  (sprite_slot),
        .draw_x       (draw_x),
        .draw_y       (draw_y),
        .shape_out    (shape_out),
        .under_offset (under_offset),
        .last         (last)
    );

    // mode writes only while idle and no item is offered
    assign busy      = busy_int;
    assign cfg_ready = !busy_int && !start;

endmodule

// ===== dv/save_under_sprite_sequencer_core_tb.sv =====
// self-checking testbench for save_under_sprite_sequencer_core: a directed frame script,
// then random command phases in both buffer modes, checked by a cycle-free sequencer model
// depends on susq_pkg and the top level in hdl
module save_under_sprite_sequencer_core_tb;
    import susq_pkg::*;

    localparam int NUM_SLOTS   = SLOTS_DEF;
    localparam int SAVE_BYTES  = UNDER_BYTES_DEF;
    localparam int SETTLE      = 12;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 41;

    // command codes that the block acknowledges without effect
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam logic MODE_SINGLE = 1'b0;
    localparam logic MODE_DOUBLE = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  slot;
        logic [7:0]  shape;
        logic [7:0]  stride;
        logic [7:0]  rows;
        logic [15:0] x;
        logic [7:0]  y;
    } sprite_cmd_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  status;
        logic        page;
        logic [2:0]  slot;
        logic [8:0]  x;
        logic [7:0]  y;
        logic [7:0]  shape;
        logic [10:0] offset;
        logic        last;
    } blit_op_t;

    // one line of the directed frame script: a mode write or a command item
    typedef struct packed {
        logic        is_mode;
        logic        mode;
        sprite_cmd_t cmd;
        logic        typed;
        logic [1:0]  typed_status;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  command = '0;
    logic [7:0]  slot = '0;
    logic [7:0]  shape_handle = '0;
    logic [7:0]  shape_stride = '0;
    logic [7:0]  shape_rows = '0;
    logic [15:0] x_pos = '0;
    logic [7:0]  y_pos = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        two_page = 1'b0;
    logic        result_valid;
    logic [2:0]  op;
    logic [1:0]  status;
    logic        page_index;
    logic [2:0]  sprite_slot;
    logic [8:0]  draw_x;
    logic [7:0]  draw_y;
    logic [7:0]  shape_out;
    logic [10:0] under_offset;
    logic        last;

    // sequencer model state
    logic [7:0]  shape_tab [NUM_SLOTS];
    logic [15:0] tgt_x [NUM_SLOTS];
    logic [7:0]  tgt_y [NUM_SLOTS];
    logic        active_tab [NUM_SLOTS];
    logic [8:0]  drawn_x [2][NUM_SLOTS];
    logic [7:0]  drawn_y [2][NUM_SLOTS];
    logic        drawn_on [2][NUM_SLOTS];
    logic        page_sel;
    logic        mode_reg;

    blit_op_t    pending_ops [$];
    script_row_t frame_script [$];
    int          mismatches = 0;
    int          cycle_count = 0;

    save_under_sprite_sequencer_core #(
        .SLOTS       (NUM_SLOTS),
        .UNDER_BYTES (SAVE_BYTES)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .slot            (slot),
        .shape_handle    (shape_handle),
        .shape_stride    (shape_stride),
        .shape_rows      (shape_rows),
        .x_pos           (x_pos),
        .y_pos           (y_pos),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .two_page        (two_page),
        .result_valid    (result_valid),
        .op              (op),
        .status          (status),
        .page_index      (page_index),
        .sprite_slot     (sprite_slot),
        .draw_x          (draw_x),
        .draw_y          (draw_y),
        .shape_out       (shape_out),
        .under_offset    (under_offset),
        .last            (last)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("save_under_sprite_sequencer_core_tb: FAIL");
            $finish;
        end
    end

    function automatic blit_op_t mk_op(input op_t o, input logic [1:0] st, input logic pg,
                                       input int s, input logic [8:0] px, input logic [7:0] py,
                                       input logic [7:0] sh);
        blit_op_t r;
        r.op     = o;
        r.status = st;
        r.page   = pg;
        r.slot   = s[2:0];
        r.x      = px;
        r.y      = py;
        r.shape  = sh;
        // save buffer offset only matters for restore and draw
        r.offset = (o == OP_RESTORE || o == OP_DRAW) ?
                   11'((int'(pg) * NUM_SLOTS + s) * SAVE_BYTES) : 11'd0;
        r.last   = 1'b0;
        return r;
    endfunction

    // frame operations caused by one command item
    task automatic predict_ops(input sprite_cmd_t c);
        int         i;
        logic       pg;
        logic [1:0] st;
        blit_op_t   tail;
        st = ST_OK;
        if (c.cmd == CMD_INIT)
        begin
            for (i = 0; i < NUM_SLOTS; i++)
            begin
                shape_tab[i]   = '0;
                active_tab[i]  = 1'b0;
                drawn_on[0][i] = 1'b0;
                drawn_on[1][i] = 1'b0;
            end
            pending_ops.push_back(mk_op(OP_SELECT, ST_OK, 1'b0, 0, '0, '0, '0));
            pending_ops.push_back(mk_op(OP_SHOW, ST_OK, 1'b0, 0, '0, '0, '0));
            if (mode_reg)
            begin
                page_sel = 1'b1;
                pending_ops.push_back(mk_op(OP_SELECT, ST_OK, 1'b1, 0, '0, '0, '0));
            end
            else
                page_sel = 1'b0;
        end
        else if (c.cmd == CMD_UPDATE)
        begin
            pg = page_sel;
            if (!mode_reg)
                pending_ops.push_back(mk_op(OP_WAIT, ST_OK, 1'b0, 0, '0, '0, '0));
            pending_ops.push_back(mk_op(OP_SELECT, ST_OK, pg, 0, '0, '0, '0));
            // restore walk, highest slot first
            for (i = NUM_SLOTS - 1; i >= 0; i--)
            begin
                if (drawn_on[pg][i])
                begin
                    pending_ops.push_back(mk_op(OP_RESTORE, ST_OK, pg, i, drawn_x[pg][i],
                                                drawn_y[pg][i], shape_tab[i]));
                    drawn_on[pg][i] = 1'b0;
                end
            end
            // draw walk, lowest slot first, on-screen only
            for (i = 0; i < NUM_SLOTS; i++)
            begin
                if (active_tab[i] && shape_tab[i] != 0 && tgt_x[i] <= X_MAX && tgt_y[i] <= Y_MAX)
                begin
                    pending_ops.push_back(mk_op(OP_DRAW, ST_OK, pg, i, tgt_x[i][8:0], tgt_y[i],
                                                shape_tab[i]));
                    drawn_x[pg][i]  = tgt_x[i][8:0];
                    drawn_y[pg][i]  = tgt_y[i];
                    drawn_on[pg][i] = 1'b1;
                end
            end
            if (mode_reg)
            begin
                pending_ops.push_back(mk_op(OP_WAIT, ST_OK, 1'b0, 0, '0, '0, '0));
                pending_ops.push_back(mk_op(OP_SHOW, ST_OK, pg, 0, '0, '0, '0));
                page_sel = ~pg;
            end
        end
        else
        begin
            if ((c.cmd == CMD_DEFINE || c.cmd == CMD_MOVE || c.cmd == CMD_HIDE) &&
                c.slot >= NUM_SLOTS)
                st = ST_RANGE;
            else if (c.cmd == CMD_DEFINE)
            begin
                if (c.shape != 0 && int'(c.stride) * int'(c.rows) > SAVE_BYTES)
                begin
                    shape_tab[c.slot]  = '0;
                    active_tab[c.slot] = 1'b0;
                    st = ST_OVERSIZE;
                end
                else
                begin
                    shape_tab[c.slot]  = c.shape;
                    active_tab[c.slot] = (c.shape != 0);
                end
            end
            else if (c.cmd == CMD_MOVE)
            begin
                tgt_x[c.slot]      = c.x;
                tgt_y[c.slot]      = c.y;
                active_tab[c.slot] = (shape_tab[c.slot] != 0);
            end
            else if (c.cmd == CMD_HIDE)
                active_tab[c.slot] = 1'b0;
            pending_ops.push_back(mk_op(OP_ACK, st, 1'b0, 0, '0, '0, '0));
        end
        // mark the end of the run
        tail = pending_ops.pop_back();
        tail.last = 1'b1;
        pending_ops.push_back(tail);
    endtask

    // one item on the command port; returns at the accepting edge
    task automatic send_cmd(input sprite_cmd_t c, input logic typed, input logic [1:0] typed_st);
        blit_op_t ack;
        start        <= 1'b1;
        command      <= c.cmd;
        slot         <= c.slot;
        shape_handle <= c.shape;
        shape_stride <= c.stride;
        shape_rows   <= c.rows;
        x_pos        <= c.x;
        y_pos        <= c.y;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        predict_ops(c);
        // a script row with a hand-written acknowledge replaces the predicted one
        if (typed)
        begin
            void'(pending_ops.pop_back());
            ack = mk_op(OP_ACK, typed_st, 1'b0, 0, '0, '0, '0);
            ack.last = 1'b1;
            pending_ops.push_back(ack);
        end
    endtask

    task automatic idle_gap(input bit allow);
        int n;
        n = (allow && $urandom_range(99) < 29) ? $urandom_range(6, 1) : 0;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // hold off until every expected operation is out and the block is idle
    task automatic quiet_down();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || busy);
        @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_valid <= 1'b1;
        two_page  <= m;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        mode_reg  = m;
    endtask

    task automatic add_item(input logic [2:0] c, input logic [7:0] s, input logic [7:0] sh,
                            input logic [7:0] str, input logic [7:0] r, input logic [15:0] px,
                            input logic [7:0] py, input logic typed, input logic [1:0] st);
        script_row_t row;
        row.is_mode      = 1'b0;
        row.mode         = MODE_SINGLE;
        row.cmd          = '{c, s, sh, str, r, px, py};
        row.typed        = typed;
        row.typed_status = st;
        frame_script.push_back(row);
    endtask

    task automatic add_mode(input logic m);
        script_row_t row;
        row         = '0;
        row.is_mode = 1'b1;
        row.mode    = m;
        frame_script.push_back(row);
    endtask

    // mostly well-formed sprite traffic, some range errors, oversize shapes and spare codes
    function automatic sprite_cmd_t random_cmd();
        sprite_cmd_t c;
        int          pick;
        c.cmd    = CMD_UPDATE;
        c.slot   = 8'($urandom);
        c.shape  = 8'($urandom);
        c.stride = 8'($urandom);
        c.rows   = 8'($urandom);
        c.x      = 16'($urandom);
        c.y      = 8'($urandom);
        pick     = $urandom_range(99);
        if (pick < 3)
            c.cmd = CMD_INIT;
        else if (pick < 28)
        begin
            c.cmd  = CMD_DEFINE;
            c.slot = 8'($urandom_range(NUM_SLOTS - 1));
            if ($urandom_range(9) == 0)
                c.shape = '0;
            else if (c.shape == 0)
                c.shape = 8'd1;
            if ($urandom_range(9) != 0)
            begin
                c.stride = 8'($urandom_range(12, 1));
                c.rows   = 8'($urandom_range(8));
            end
        end
        else if (pick < 55)
        begin
            c.cmd  = CMD_MOVE;
            c.slot = 8'($urandom_range(NUM_SLOTS - 1));
            if ($urandom_range(99) >= 15)
            begin
                c.x = 16'($urandom_range(X_MAX));
                c.y = 8'($urandom_range(Y_MAX));
            end
        end
        else if (pick < 65)
        begin
            c.cmd  = CMD_HIDE;
            c.slot = 8'($urandom_range(NUM_SLOTS - 1));
        end
        else if (pick < 88)
            c.cmd = CMD_UPDATE;
        else if (pick < 95)
        begin
            c.cmd  = 3'($urandom_range(CMD_HIDE, CMD_DEFINE));
            c.slot = 8'($urandom_range(255, NUM_SLOTS));
        end
        else
            c.cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        return c;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // checker: results are sampled mid-cycle, one cycle strobe
    always @(negedge clk)
    begin
        blit_op_t want;
        if (rst_n && result_valid)
        begin
            if (pending_ops.size() == 0)
            begin
                $display("%0t: result with nothing expected: expected none, got op %0d", $time, op);
                mismatches++;
            end
            else
            begin
                want = pending_ops.pop_front();
                check_field("op", want.op, op);
                check_field("status", want.status, status);
                check_field("page_index", want.page, page_index);
                check_field("sprite_slot", want.slot, sprite_slot);
                check_field("draw_x", want.x, draw_x);
                check_field("draw_y", want.y, draw_y);
                check_field("shape_out", want.shape, shape_out);
                check_field("under_offset", want.offset, under_offset);
                check_field("last", want.last, last);
            end
        end
    end

    initial
    begin
        script_row_t row;
        sprite_cmd_t c;
        int          r;
        int          p;
        int          n;

        for (r = 0; r < NUM_SLOTS; r++)
        begin
            shape_tab[r]   = '0;
            tgt_x[r]       = '0;
            tgt_y[r]       = '0;
            active_tab[r]  = 1'b0;
            drawn_x[0][r]  = '0;
            drawn_x[1][r]  = '0;
            drawn_y[0][r]  = '0;
            drawn_y[1][r]  = '0;
            drawn_on[0][r] = 1'b0;
            drawn_on[1][r] = 1'b0;
        end
        page_sel = 1'b0;
        mode_reg = MODE_SINGLE;

        // frame script: range and size errors, edges of the screen, restore of a
        // cleared shape, mode changes with and without init
        add_item(CMD_UPDATE, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, ST_OK);
        add_item(CMD_DEFINE, 8'd8, 8'd1, 8'd1, 8'd1, 16'd0, 8'd0, 1'b1, ST_RANGE);
        add_item(CMD_MOVE, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 8'hff, 1'b1, ST_RANGE);
        add_item(CMD_HIDE, 8'd128, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b1, ST_RANGE);
        add_item(CMD_SPARE_LO, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 8'hff, 1'b1, ST_OK);
        add_item(CMD_DEFINE, 8'd0, 8'hff, 8'hff, 8'hff, 16'd0, 8'd0, 1'b1, ST_OVERSIZE);
        add_item(CMD_DEFINE, 8'd1, 8'h01, 8'd96, 8'd1, 16'd0, 8'd0, 1'b1, ST_OK);
        add_item(CMD_DEFINE, 8'd2, 8'h00, 8'hff, 8'hff, 16'd0, 8'd0, 1'b1, ST_OK);
        add_item(CMD_DEFINE, 8'd0, 8'ha5, 8'd8, 8'd12, 16'd0, 8'd0, 1'b1, ST_OK);
        add_item(CMD_MOVE, 8'd0, 8'd0, 8'd0, 8'd0, 16'd279, 8'd191, 1'b1, ST_OK);
        add_item(CMD_MOVE, 8'd1, 8'd0, 8'd0, 8'd0, 16'd280, 8'd0, 1'b1, ST_OK);
        add_item(CMD_DEFINE, 8'd7, 8'h5a, 8'd1, 8'd1, 16'd0, 8'd0, 1'b1, ST_OK);
        add_item(CMD_MOVE, 8'd7, 8'd0, 8'd0, 8'd0, 16'd0, 8'd192, 1'b1, ST_OK);
        add_item(CMD_DEFINE, 8'd6, 8'h3c, 8'd4, 8'd4, 16'd0, 8'd0, 1'b1, ST_OK);
        add_item(CMD_MOVE, 8'd6, 8'd0, 8'd0, 8'd0, 16'd100, 8'd50, 1'b1, ST_OK);
        add_item(CMD_UPDATE, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, ST_OK);
        add_item(CMD_DEFINE, 8'd0, 8'h09, 8'd97, 8'd1, 16'd0, 8'd0, 1'b1, ST_OVERSIZE);
        add_item(CMD_HIDE, 8'd6, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b1, ST_OK);
        add_item(CMD_UPDATE, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, ST_OK);
        add_mode(MODE_DOUBLE);
        add_item(CMD_UPDATE, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, ST_OK);
        add_item(CMD_INIT, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, ST_OK);
        add_item(CMD_DEFINE, 8'd3, 8'h11, 8'd2, 8'd2, 16'd0, 8'd0, 1'b1, ST_OK);
        add_item(CMD_MOVE, 8'd3, 8'd0, 8'd0, 8'd0, 16'd10, 8'd20, 1'b1, ST_OK);
        add_item(CMD_UPDATE, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, ST_OK);
        add_item(CMD_UPDATE, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, ST_OK);
        add_mode(MODE_SINGLE);
        add_item(CMD_UPDATE, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, ST_OK);

        // reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frame script
        for (r = 0; r < frame_script.size(); r++)
        begin
            row = frame_script[r];
            if (row.is_mode)
            begin
                quiet_down();
                write_mode(row.mode);
            end
            else
            begin
                idle_gap(1'b1);
                send_cmd(row.cmd, row.typed, row.typed_status);
            end
        end

        // random phases, alternating modes; the middle phase runs without gaps
        for (p = 0; p < PHASES; p++)
        begin
            quiet_down();
            write_mode((p % 2 == 0) ? MODE_DOUBLE : MODE_SINGLE);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                c = random_cmd();
                if (n == 0 && (p == 2 || p == 3))
                    c.cmd = CMD_INIT;
                if (p == 1 && n == PHASE_ITEMS / 2)
                    quiet_down();
                else
                    idle_gap(p != 2);
                send_cmd(c, 1'b0, ST_OK);
            end
        end

        // drain and let the block settle
        quiet_down();
        if (mismatches == 0)
            $display("save_under_sprite_sequencer_core_tb: PASS");
        else
            $display("save_under_sprite_sequencer_core_tb: FAIL");
        $finish;
    end

endmodule
